// File: rtl/msm_pkg.sv
package msm_pkg;

  localparam int PosW  = 18;
  localparam int StepW = 18;
  localparam int TimeW = 31;
  localparam int GainW = 7;
  localparam int AccW  = 24;
  localparam int MulW  = 24;

  localparam logic [15:0]      HandleFirst = 16'd100;
  localparam logic [MulW-1:0]  Recip127    = 24'd8454661;
  localparam logic [7:0]       Silence     = 8'd128;
  localparam logic signed [AccW-1:0] SatMax = 24'sd32767;
  localparam logic signed [AccW-1:0] SatMin = -24'sd32768;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic {
    RES_HANDLE = 1'b0,
    RES_FRAME  = 1'b1
  } res_kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXCL,
    S_SCAN,
    S_G1,
    S_G2,
    S_G3,
    S_G4,
    S_G5,
    S_RED,
    S_COMMIT,
    S_T_RD,
    S_T_ML1,
    S_T_ML2,
    S_T_MR1,
    S_T_MR2,
    S_T_ADV,
    S_DONE
  } state_t;

  typedef logic [StepW-1:0] step_rom_t [256];

  function automatic step_rom_t build_step_rom();
    step_rom_t rom;
    real       r;
    for (int i = 0; i < 256; i++) begin
      r = (2.0 ** ((i - 128) / 64.0)) * 65536.0;
      rom[i] = StepW'($rtoi(r + 1.0e-6));
    end
    return rom;
  endfunction

  localparam step_rom_t StepRom = build_step_rom();

endpackage

// File: rtl/msm_if.sv
interface msm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] write_addr;
  logic [7:0]  write_byte;
  logic [7:0]  sfx_id;
  logic [15:0] start_addr;
  logic [16:0] sample_length;
  logic [6:0]  volume;
  logic [7:0]  separation;
  logic [7:0]  pitch;
  logic        exclusive;
  logic [30:0] game_time;

  modport source (output valid, kind, write_addr, write_byte, sfx_id, start_addr,
                  sample_length, volume, separation, pitch, exclusive, game_time,
                  input ready);
  modport sink (input valid, kind, write_addr, write_byte, sfx_id, start_addr,
                sample_length, volume, separation, pitch, exclusive, game_time,
                output ready);
endinterface

interface msm_out_if;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [15:0]        handle;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;

  modport source (output valid, result_kind, handle, left_sample, right_sample,
                  input ready);
  modport sink (input valid, result_kind, handle, left_sample, right_sample,
                output ready);
endinterface

// File: rtl/multichannel_sample_mixer.sv
// PCM voice mixer: one request at a time through a shared 24x24 multiplier under
// a sequencer. A write wraps its address by subtracting the depth (no wrap step
// when the sample memory holds 65536 bytes or more), then stores the byte. A
// start frees a voice of the same id if exclusive, scans for a free or oldest
// voice, runs the four gain multiplies and the address wrap, then commits. A
// tick does a memory read, two multiplies per channel and an advance per active
// voice. The result register lets a new request in while the last result waits.
module multichannel_sample_mixer #(
  parameter int VOICES           = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic clk,
  input  logic rst,
  msm_in_if.sink    in_ch,
  msm_out_if.source out_ch
);
  import msm_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
  localparam int RW = (AW + 1 > 16) ? AW + 1 : 16;
  localparam logic [RW-1:0] DepthR = RW'(SAMPLE_MEM_DEPTH);
  localparam logic [AW:0]   DepthA = (AW + 1)'(SAMPLE_MEM_DEPTH);
  localparam logic [VW-1:0] LastV  = VW'(VOICES - 1);

  state_t state, state_next;

  logic [7:0] mem [SAMPLE_MEM_DEPTH];
  logic [7:0] mdat;

  logic             v_active [VOICES];
  logic [PosW-1:0]  v_pos    [VOICES];
  logic [PosW-1:0]  v_end    [VOICES];
  logic [15:0]      v_frac   [VOICES];
  logic [StepW-1:0] v_step   [VOICES];
  logic [TimeW-1:0] v_time   [VOICES];
  logic [7:0]       v_id     [VOICES];
  logic [GainW-1:0] v_gl     [VOICES];
  logic [GainW-1:0] v_gr     [VOICES];
  logic [AW-1:0]    v_addr   [VOICES];

  kind_t            op;
  logic [7:0]       r_id;
  logic [15:0]      r_start;
  logic [16:0]      r_len;
  logic [6:0]       r_vol;
  logic [7:0]       r_sep;
  logic [7:0]       r_pitch;
  logic             r_excl;
  logic [TimeW-1:0] r_now;
  logic [7:0]       r_wbyte;
  logic [RW-1:0]    red;
  logic [GainW-1:0] gl, gr;

  logic [VW-1:0]    idx, slot, oldest_num;
  logic [TimeW-1:0] oldest;
  logic [15:0]      counter;

  logic [MulW-1:0]   mul_a, mul_b;
  logic [2*MulW-1:0] prod;

  logic signed [AccW-1:0] acc_l, acc_r;

  logic        out_valid;
  res_kind_t   out_kind;
  logic [15:0] out_handle;
  logic signed [15:0] out_left, out_right;

  logic              excl_hit;
  logic [VW-1:0]     excl_num;
  logic              neg;
  logic [7:0]        absd;
  logic [15:0]       q;
  logic signed [AccW-1:0] term;
  logic [8:0]        sep1, sepu;
  logic signed [8:0] gain_raw;
  logic [GainW-1:0]  gain_clamped;
  logic [18:0]       frac_sum;
  logic [PosW-1:0]   pos_new;
  logic [AW:0]       addr_sum, addr_new;
  logic [15:0]       handle_now;
  logic              load_out;

  assign in_ch.ready = (state == S_IDLE);

  always_comb begin
    excl_hit = 1'b0;
    excl_num = '0;
    for (int v = 0; v < VOICES; v++) begin
      if (!excl_hit && v_active[v] && v_id[v] == r_id) begin
        excl_hit = 1'b1;
        excl_num = VW'(v);
      end
    end
  end

  assign neg  = (mdat < Silence);
  assign absd = neg ? (Silence - mdat) : (mdat - Silence);
  assign q    = prod[45:30];
  assign term = neg ? -AccW'($signed({1'b0, q})) : AccW'($signed({1'b0, q}));

  assign sep1 = {1'b0, r_sep} + 9'd1;
  assign sepu = 9'd256 - {1'b0, r_sep};
  assign gain_raw = $signed({2'b00, r_vol}) - $signed({2'b00, prod[22:16]});
  assign gain_clamped = (gain_raw < 0) ? '0 :
                        (gain_raw > 9'sd127) ? 7'd127 : gain_raw[6:0];

  assign frac_sum = {3'b000, v_frac[idx]} + {1'b0, v_step[idx]};
  assign pos_new  = v_pos[idx] + PosW'(frac_sum[18:16]);
  assign addr_sum = {1'b0, v_addr[idx]} + (AW + 1)'(frac_sum[18:16]);
  assign addr_new = (addr_sum >= DepthA) ? addr_sum - DepthA : addr_sum;

  assign handle_now = (counter == 16'd0) ? HandleFirst : counter;
  assign load_out   = (state == S_DONE) && (!out_valid || out_ch.ready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_G1: begin
        mul_a = MulW'(sep1);
        mul_b = MulW'(sep1);
      end
      S_G2, S_G4: begin
        mul_a = MulW'(r_vol);
        mul_b = MulW'(prod[16:0]);
      end
      S_G3: begin
        mul_a = MulW'(sepu);
        mul_b = MulW'(sepu);
      end
      S_T_ML1: begin
        mul_a = MulW'(v_gl[idx]);
        mul_b = MulW'(absd);
      end
      S_T_MR1: begin
        mul_a = MulW'(v_gr[idx]);
        mul_b = MulW'(absd);
      end
      S_T_ML2, S_T_MR2: begin
        mul_a = {2'b00, prod[13:0], 8'd0};
        mul_b = Recip127;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (kind_t'(in_ch.kind))
            KIND_WRITE: state_next = S_RED;
            KIND_START: state_next = S_EXCL;
            KIND_TICK:  state_next = S_T_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_EXCL: state_next = S_SCAN;
      S_SCAN: begin
        if (!v_active[idx] || idx == LastV) state_next = S_G1;
      end
      S_G1: state_next = S_G2;
      S_G2: state_next = S_G3;
      S_G3: state_next = S_G4;
      S_G4: state_next = S_G5;
      S_G5: state_next = S_RED;
      S_RED: begin
        if (red < DepthR) state_next = (op == KIND_WRITE) ? S_IDLE : S_COMMIT;
      end
      S_COMMIT: state_next = S_DONE;
      S_T_RD: begin
        if (v_active[idx]) state_next = S_T_ML1;
        else if (idx == LastV) state_next = S_DONE;
      end
      S_T_ML1: state_next = S_T_ML2;
      S_T_ML2: state_next = S_T_MR1;
      S_T_MR1: state_next = S_T_MR2;
      S_T_MR2: state_next = S_T_ADV;
      S_T_ADV: state_next = (idx == LastV) ? S_DONE : S_T_RD;
      S_DONE: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RED && red < DepthR && op == KIND_WRITE) begin
      mem[red[AW-1:0]] <= r_wbyte;
    end
    if (state == S_T_RD && v_active[idx]) begin
      mdat <= mem[v_addr[idx]];
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int v = 0; v < VOICES; v++) begin
        v_active[v] <= 1'b0;
      end
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (state == S_EXCL && r_excl && excl_hit) v_active[excl_num] <= 1'b0;
      if (state == S_COMMIT) begin
        v_active[slot] <= 1'b1;
        counter        <= handle_now + 16'd1;
      end
      if (state == S_T_ADV && pos_new >= v_end[idx]) v_active[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          op      <= kind_t'(in_ch.kind);
          r_id    <= in_ch.sfx_id;
          r_start <= in_ch.start_addr;
          r_len   <= in_ch.sample_length;
          r_vol   <= in_ch.volume;
          r_sep   <= in_ch.separation;
          r_pitch <= in_ch.pitch;
          r_excl  <= in_ch.exclusive;
          r_now   <= in_ch.game_time;
          r_wbyte <= in_ch.write_byte;
          oldest  <= in_ch.game_time;
          oldest_num <= '0;
          idx     <= '0;
          acc_l   <= '0;
          acc_r   <= '0;
          if (kind_t'(in_ch.kind) == KIND_WRITE) red <= RW'(in_ch.write_addr);
          else red <= RW'(in_ch.start_addr);
        end
      end
      S_SCAN: begin
        if (!v_active[idx]) begin
          slot <= idx;
        end else begin
          if (v_time[idx] < oldest) begin
            oldest     <= v_time[idx];
            oldest_num <= idx;
          end
          if (idx == LastV) slot <= (v_time[idx] < oldest) ? idx : oldest_num;
          else idx <= idx + VW'(1);
        end
      end
      S_G3: gl <= gain_clamped;
      S_G5: gr <= gain_clamped;
      S_RED: begin
        if (red >= DepthR) red <= red - DepthR;
      end
      S_COMMIT: begin
        v_pos[slot]  <= PosW'(r_start);
        v_end[slot]  <= PosW'(r_start) + PosW'(r_len);
        v_frac[slot] <= '0;
        v_step[slot] <= StepRom[r_pitch];
        v_time[slot] <= r_now;
        v_id[slot]   <= r_id;
        v_gl[slot]   <= gl;
        v_gr[slot]   <= gr;
        v_addr[slot] <= red[AW-1:0];
      end
      S_T_RD: begin
        if (!v_active[idx] && idx != LastV) idx <= idx + VW'(1);
      end
      S_T_MR1: acc_l <= acc_l + term;
      S_T_ADV: begin
        acc_r        <= acc_r + term;
        v_frac[idx]  <= frac_sum[15:0];
        v_pos[idx]   <= pos_new;
        v_addr[idx]  <= addr_new[AW-1:0];
        if (idx != LastV) idx <= idx + VW'(1);
      end
      default: begin
      end
    endcase
    if (load_out) begin
      if (op == KIND_TICK) begin
        out_kind   <= RES_FRAME;
        out_handle <= '0;
        out_left   <= (acc_l > SatMax) ? 16'sh7fff : (acc_l < SatMin) ? -16'sh8000 :
                      acc_l[15:0];
        out_right  <= (acc_r > SatMax) ? 16'sh7fff : (acc_r < SatMin) ? -16'sh8000 :
                      acc_r[15:0];
      end else begin
        out_kind   <= RES_HANDLE;
        out_handle <= counter - 16'd1;
        out_left   <= '0;
        out_right  <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.result_kind  = out_kind;
  assign out_ch.handle       = out_handle;
  assign out_ch.left_sample  = out_left;
  assign out_ch.right_sample = out_right;

`ifndef SYNTHESIS
  a_frame_no_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == RES_FRAME |-> out_handle == 16'd0)
    else $error("frame result carries a handle");

  a_commit_claims: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |=> v_active[slot])
    else $error("started voice not active");

  a_addr_reduced: assert property (@(posedge clk) disable iff (rst)
    state == S_COMMIT |-> red < DepthR)
    else $error("start address not wrapped");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid && state == S_IDLE)
    else $error("result not presented");
`endif

endmodule
